@@ rtl/lzd_pkg.sv @@
// lzd_pkg: shared types and constants of the literal/copy decompressor
package lzd_pkg;

  // item kinds on the input channel
  typedef enum logic {
    OP_BYTE  = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  // command byte forms, taken from the top three bits
  localparam logic [2:0] KIND_LIT_RUN   = 3'd7;
  localparam logic [2:0] KIND_FIRST_3B  = 3'd4;
  localparam logic [2:0] KIND_FIRST_4B  = 3'd6;

  // header bytes still to come after the first byte
  localparam logic [1:0] HDR_LEFT_2B = 2'd1;
  localparam logic [1:0] HDR_LEFT_3B = 2'd2;
  localparam logic [1:0] HDR_LEFT_4B = 2'd3;

  // copy length bias of each header form
  localparam logic [10:0] COPY_BIAS_2B = 11'd3;
  localparam logic [10:0] COPY_BIAS_3B = 11'd4;
  localparam logic [10:0] COPY_BIAS_4B = 11'd5;

  localparam int unsigned OFFSET_W = 17;
  localparam int unsigned COPY_W   = 11;
  localparam int unsigned LIT_W    = 8;

  typedef struct packed {
    op_e        operation;
    logic [7:0] in_byte;
  } lzd_in_t;

  typedef struct packed {
    logic              out_valid;
    logic [7:0]        out_byte;
    logic [COPY_W-1:0] copies_left;
    logic [LIT_W-1:0]  literals_left;
    logic              header_pending;
    logic              rejected;
  } lzd_out_t;

endpackage

@@ rtl/lzd_stream_if.sv @@
// lzd_stream_if: valid/ready channel with a typed payload
interface lzd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/lzd_history_ram.sv @@
// lzd_history_ram: history memory, one write and one registered read port
module lzd_history_ram #(
  parameter int unsigned ADDR_W = 16
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [7:0]        wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [7:0]        rdata_o
);
  localparam int unsigned DEPTH = 1 << ADDR_W;

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  // write port, read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

@@ rtl/lz_literal_copy_decompressor_unit.sv @@
// lz_literal_copy_decompressor_unit: top level of the literal/copy decompressor
//
// in_i carries one request per item: a compressed byte (operation = byte)
// or a request to drain one pending back-reference byte (operation = drain).
// out_o returns exactly one result per request, in order: the literal or
// copied byte when out_valid is set, plus the remaining copy and literal
// counts, the header-pending flag and a rejected flag.
// A request accepted at a clock edge sits in the read stage, then moves to
// the result register, which drives out_o. While out_o does not stall, the
// unit takes one request per cycle, drains included, also for overlapping
// copies with offset one, since a history read forwards the write still in
// flight. The rate is set by one history read and one write-back per cycle
// on the separate read and write ports of the history memory.
// Reset clears all counters and the write pointer; the history memory is not
// swept: a fill pointer and a wrap flag mark which entries hold data, and a
// read of an entry never written returns zero.
// When out_o stalls, the result register holds, one more request may sit in
// the read stage, and in_i.ready drops until the result is taken.
module lz_literal_copy_decompressor_unit
  import lzd_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = 65536
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  lzd_stream_if.sink   in_i,
  lzd_stream_if.source out_o
);
  localparam int unsigned AW = $clog2(HISTORY_DEPTH);

  typedef struct packed {
    logic [1:0]          lit;
    logic [COPY_W-1:0]   cpy;
    logic [OFFSET_W-1:0] off;
  } hdr_fields_t;

  // header decode of the assembled command word
  function automatic hdr_fields_t decode_header(logic [31:0] v);
    hdr_fields_t h;
    if (|v[31:24]) begin
      h.lit = v[28:27];
      h.cpy = COPY_W'({v[26:24], 7'b0}) + COPY_W'(v[7:0]) + COPY_BIAS_4B;
      h.off = OFFSET_W'(v[23:8]) + OFFSET_W'(1);
    end else if (|v[23:16]) begin
      h.lit = v[15:14];
      h.cpy = COPY_W'(v[21:16]) + COPY_BIAS_3B;
      h.off = OFFSET_W'(v[13:0]) + OFFSET_W'(1);
    end else begin
      h.lit = v[11:10];
      h.cpy = COPY_W'(v[14:12]) + COPY_BIAS_2B;
      h.off = OFFSET_W'(v[9:0]) + OFFSET_W'(1);
    end
    return h;
  endfunction

  // decoder state
  logic [AW-1:0]       wp_q, wp_d;
  logic                wrapped_q, wrapped_d;
  logic [23:0]         shift_q, shift_d;
  logic [1:0]          hdr_left_q, hdr_left_d;
  logic [LIT_W-1:0]    lit_q, lit_d;
  logic [COPY_W-1:0]   copy_q, copy_d;
  logic [OFFSET_W-1:0] off_q, off_d;
  logic [COPY_W-1:0]   held_q, held_d;

  // read stage
  logic          s2_valid_q;
  lzd_out_t      s2_res_q, s2_res_d;
  logic          s2_mem_q, s2_mem_d;
  logic          s2_zero_q, s2_zero_d;
  logic          s2_fwd_q, s2_fwd_d;
  logic [7:0]    s2_fwd_data_q, s2_fwd_data_d;
  logic          s2_we_q, s2_we_d;
  logic [AW-1:0] s2_waddr_q, s2_waddr_d;

  // result register
  logic     out_valid_q;
  lzd_out_t out_res_q;

  logic          in_fire, s2_adv;
  logic [AW:0]   rd_diff;
  logic [AW-1:0] rd_addr;
  logic          rd_en;
  logic [7:0]    ram_rdata, s2_byte;
  lzd_in_t       req;
  logic [31:0]   hdr_word;
  hdr_fields_t   hdr;

  // handshake
  assign s2_adv    = s2_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s2_valid_q || s2_adv;
  assign in_fire   = in_i.valid && in_i.ready;
  assign req       = in_i.payload;

  // history read address for a drain
  assign rd_diff = {1'b0, wp_q} - (AW + 1)'(off_q);
  assign rd_addr = rd_diff[AW-1:0];

  assign hdr_word = {shift_q, req.in_byte};
  assign hdr      = decode_header(hdr_word);

  // byte leaving the read stage
  always_comb begin
    if (!s2_mem_q) begin
      s2_byte = s2_res_q.out_byte;
    end else if (s2_zero_q) begin
      s2_byte = 8'd0;
    end else if (s2_fwd_q) begin
      s2_byte = s2_fwd_data_q;
    end else begin
      s2_byte = ram_rdata;
    end
  end

  // state update per accepted request
  always_comb begin
    wp_d       = wp_q;
    wrapped_d  = wrapped_q;
    shift_d    = shift_q;
    hdr_left_d = hdr_left_q;
    lit_d      = lit_q;
    copy_d     = copy_q;
    off_d      = off_q;
    held_d     = held_q;
    rd_en      = 1'b0;
    s2_res_d   = '0;
    s2_mem_d   = 1'b0;
    s2_we_d    = 1'b0;
    s2_waddr_d = wp_q;
    s2_zero_d  = !(wrapped_q || (rd_addr < wp_q));
    s2_fwd_d   = s2_valid_q && s2_we_q && (s2_waddr_q == rd_addr);
    s2_fwd_data_d = s2_byte;

    if (in_fire) begin
      unique case (req.operation)
        OP_DRAIN: begin
          if (copy_q != '0) begin
            rd_en              = 1'b1;
            s2_mem_d           = 1'b1;
            s2_we_d            = 1'b1;
            s2_res_d.out_valid = 1'b1;
            wp_d               = wp_q + AW'(1);
            wrapped_d          = wrapped_q || (&wp_q);
            copy_d             = copy_q - COPY_W'(1);
          end else begin
            s2_res_d.rejected = 1'b1;
          end
        end
        OP_BYTE: begin
          priority if (copy_q != '0) begin
            s2_res_d.rejected = 1'b1;
          end else if (hdr_left_q != '0) begin
            shift_d    = hdr_word[23:0];
            hdr_left_d = hdr_left_q - 2'd1;
            if (hdr_left_q == 2'd1) begin
              lit_d = LIT_W'(hdr.lit);
              off_d = hdr.off;
              if (hdr.lit == '0) begin
                copy_d = hdr.cpy;
                held_d = '0;
              end else begin
                held_d = hdr.cpy;
              end
            end
          end else if (lit_q != '0) begin
            s2_we_d            = 1'b1;
            s2_res_d.out_valid = 1'b1;
            s2_res_d.out_byte  = req.in_byte;
            wp_d               = wp_q + AW'(1);
            wrapped_d          = wrapped_q || (&wp_q);
            lit_d              = lit_q - LIT_W'(1);
            if (lit_q == LIT_W'(1)) begin
              copy_d = held_q;
              held_d = '0;
            end
          end else if (req.in_byte[7:5] == KIND_LIT_RUN) begin
            lit_d  = LIT_W'({1'b0, req.in_byte[4:0]} + 6'd1) << 2;
            held_d = '0;
            off_d  = '0;
          end else begin
            shift_d = 24'(req.in_byte);
            if (req.in_byte[7:5] < KIND_FIRST_3B) begin
              hdr_left_d = HDR_LEFT_2B;
            end else if (req.in_byte[7:5] < KIND_FIRST_4B) begin
              hdr_left_d = HDR_LEFT_3B;
            end else begin
              hdr_left_d = HDR_LEFT_4B;
            end
          end
        end
        default: begin
          s2_res_d.rejected = 1'b1;
        end
      endcase
    end

    // status after the update
    s2_res_d.copies_left    = copy_d + held_d;
    s2_res_d.literals_left  = lit_d;
    s2_res_d.header_pending = (hdr_left_d != '0);
  end

  // decoder state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= '0;
      wrapped_q  <= 1'b0;
      shift_q    <= '0;
      hdr_left_q <= '0;
      lit_q      <= '0;
      copy_q     <= '0;
      off_q      <= '0;
      held_q     <= '0;
    end else begin
      wp_q       <= wp_d;
      wrapped_q  <= wrapped_d;
      shift_q    <= shift_d;
      hdr_left_q <= hdr_left_d;
      lit_q      <= lit_d;
      copy_q     <= copy_d;
      off_q      <= off_d;
      held_q     <= held_d;
    end
  end

  // read stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s2_valid_q <= in_fire;
    end
  end

  // read stage payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s2_res_q      <= s2_res_d;
      s2_mem_q      <= s2_mem_d;
      s2_zero_q     <= s2_zero_d;
      s2_fwd_q      <= s2_fwd_d;
      s2_fwd_data_q <= s2_fwd_data_d;
      s2_we_q       <= s2_we_d;
      s2_waddr_q    <= s2_waddr_d;
    end
  end

  // history memory, written as a result leaves the read stage
  lzd_history_ram #(
    .ADDR_W (AW)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (s2_adv && s2_we_q),
    .waddr_i (s2_waddr_q),
    .wdata_i (s2_byte),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      out_res_q          <= s2_res_q;
      out_res_q.out_byte <= s2_byte;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_res_q;
endmodule

@@ sim/lzd_decomp_checker.sv @@
// lzd_decomp_checker: watches both channels, predicts each result and compares it
`timescale 1ns / 100ps

module lzd_decomp_checker
  import lzd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  input  logic     req_ready_i,
  input  lzd_in_t  req_i,
  input  logic     res_valid_i,
  input  logic     res_ready_i,
  input  lzd_out_t res_i,
  output int       fail_cnt_o,
  output int       pending_o,
  output lzd_out_t state_o
);

  localparam int unsigned HIST_DEPTH = 65536;

  // predicted decoder state
  logic [7:0]          hist_mem [0:HIST_DEPTH-1];
  logic [15:0]         wr_ptr;
  logic [31:0]         hdr_shift;
  logic [1:0]          hdr_left;
  logic [LIT_W-1:0]    lit_cnt;
  logic [COPY_W-1:0]   copy_cnt;
  logic [COPY_W-1:0]   held_cnt;
  logic [OFFSET_W-1:0] copy_off;

  // results predicted but not yet seen on the output
  lzd_out_t decoded_q [$];
  int       mismatch_cnt;

  assign fail_cnt_o = mismatch_cnt;

  // append one emitted byte to the history
  function automatic void put_history(logic [7:0] data);
    hist_mem[wr_ptr] = data;
    wr_ptr = wr_ptr + 16'd1;
  endfunction

  // the copy becomes drainable once all literals are in
  function automatic void release_held();
    if (lit_cnt == '0) begin
      copy_cnt = held_cnt;
      held_cnt = '0;
    end
  endfunction

  // advance the predicted state by one request and return its result
  function automatic lzd_out_t decode_request(lzd_in_t req);
    lzd_out_t    res;
    logic [15:0] rd_addr;
    logic [7:0]  data;
    res  = '0;
    data = req.in_byte;
    if (req.operation == OP_DRAIN) begin
      if (copy_cnt != '0) begin
        rd_addr = wr_ptr - copy_off[15:0];
        res.out_byte  = hist_mem[rd_addr];
        res.out_valid = 1'b1;
        put_history(res.out_byte);
        copy_cnt = copy_cnt - 1'b1;
      end else begin
        res.rejected = 1'b1;
      end
    end else if (copy_cnt != '0) begin
      // byte offered while a copy still waits
      res.rejected = 1'b1;
    end else if (hdr_left != '0) begin
      hdr_shift = {hdr_shift[23:0], data};
      hdr_left  = hdr_left - 1'b1;
      if (hdr_left == '0) begin
        // header complete: form is told by the value range
        if (hdr_shift >= 32'h0100_0000) begin
          lit_cnt  = {6'd0, hdr_shift[28:27]};
          held_cnt = {hdr_shift[26:24], 7'd0} + {3'd0, hdr_shift[7:0]} + COPY_BIAS_4B;
          copy_off = {1'b0, hdr_shift[23:8]} + 17'd1;
        end else if (hdr_shift >= 32'h0001_0000) begin
          lit_cnt  = {6'd0, hdr_shift[15:14]};
          held_cnt = {5'd0, hdr_shift[21:16]} + COPY_BIAS_3B;
          copy_off = {3'd0, hdr_shift[13:0]} + 17'd1;
        end else begin
          lit_cnt  = {6'd0, hdr_shift[11:10]};
          held_cnt = {8'd0, hdr_shift[14:12]} + COPY_BIAS_2B;
          copy_off = {7'd0, hdr_shift[9:0]} + 17'd1;
        end
        release_held();
      end
    end else if (lit_cnt != '0) begin
      put_history(data);
      res.out_byte  = data;
      res.out_valid = 1'b1;
      lit_cnt = lit_cnt - 1'b1;
      release_held();
    end else if (data[7:5] == KIND_LIT_RUN) begin
      // literal-only run of four times one more than the count field
      lit_cnt  = {1'b0, data[4:0], 2'b00} + 8'd4;
      held_cnt = '0;
      copy_off = '0;
    end else begin
      hdr_shift = {24'd0, data};
      if (data[7:5] < KIND_FIRST_3B) begin
        hdr_left = HDR_LEFT_2B;
      end else if (data[7:5] < KIND_FIRST_4B) begin
        hdr_left = HDR_LEFT_3B;
      end else begin
        hdr_left = HDR_LEFT_4B;
      end
    end
    res.copies_left    = copy_cnt + held_cnt;
    res.literals_left  = lit_cnt;
    res.header_pending = (hdr_left != '0);
    return res;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s expected %0d got %0d", name, want, got);
      mismatch_cnt++;
    end
  endfunction

  // compare each result, then predict the request accepted at this edge
  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    lzd_out_t want;
    if (!rst_ni) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist_mem[i] = '0;
      end
      wr_ptr       = '0;
      hdr_shift    = '0;
      hdr_left     = '0;
      lit_cnt      = '0;
      copy_cnt     = '0;
      held_cnt     = '0;
      copy_off     = '0;
      mismatch_cnt = 0;
      decoded_q.delete();
      state_o   <= '0;
      pending_o <= 0;
    end else begin
      if (res_valid_i && res_ready_i) begin
        if (decoded_q.size() == 0) begin
          $error("result arrived with no request outstanding");
          mismatch_cnt++;
        end else begin
          want = decoded_q.pop_front();
          check_field("out_valid", want.out_valid, res_i.out_valid);
          check_field("out_byte", want.out_byte, res_i.out_byte);
          check_field("copies_left", want.copies_left, res_i.copies_left);
          check_field("literals_left", want.literals_left, res_i.literals_left);
          check_field("header_pending", want.header_pending, res_i.header_pending);
          check_field("rejected", want.rejected, res_i.rejected);
        end
      end
      if (req_valid_i && req_ready_i) begin
        want = decode_request(req_i);
        decoded_q.push_back(want);
        state_o <= want;
      end
      pending_o <= decoded_q.size();
    end
  end

endmodule

@@ sim/lz_literal_copy_decompressor_unit_tb.sv @@
// lz_literal_copy_decompressor_unit_tb: stimulus, clock, reset and verdict for the decompressor
`timescale 1ns / 100ps

module lz_literal_copy_decompressor_unit_tb;
  import lzd_pkg::*;

  localparam int unsigned ITEM_TARGET = 850;

  logic clk_i = 1'b0;
  logic rst_ni;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned accepted_cnt;
  int          fail_cnt;
  int          pending_cnt;
  lzd_out_t    decoder_state;

  lzd_stream_if #(.payload_t(lzd_in_t))  req_ch ();
  lzd_stream_if #(.payload_t(lzd_out_t)) res_ch ();

  lz_literal_copy_decompressor_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch),
    .out_o  (res_ch)
  );

  lzd_decomp_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_ch.valid),
    .req_ready_i (req_ch.ready),
    .req_i       (req_ch.payload),
    .res_valid_i (res_ch.valid),
    .res_ready_i (res_ch.ready),
    .res_i       (res_ch.payload),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending_cnt),
    .state_o     (decoder_state)
  );

  // clock
  always #10 clk_i = ~clk_i;

  // receiver stalls at random
  always @(negedge clk_i) begin
    if (rst_ni) begin
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end else begin
      res_ch.ready <= 1'b0;
    end
  end

  // offer one request and hold it until it is taken
  task automatic send_req(input op_e op, input logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid   <= 1'b1;
    req_ch.payload <= '{operation: op, in_byte: data};
    do @(posedge clk_i); while (!req_ch.ready);
    @(negedge clk_i);
    if (!decoder_state.rejected) begin
      accepted_cnt++;
    end
  endtask

  task automatic send_byte(input logic [7:0] data);
    send_req(OP_BYTE, data);
  endtask

  task automatic send_literals(input int unsigned count);
    repeat (count) send_byte(8'($urandom_range(255)));
  endtask

  // encode one copy command, feed its literals and drain its copy
  task automatic copy_cmd(input int unsigned hdr_len, input logic [1:0] lits,
                          input int unsigned copy_len, input int unsigned offset,
                          input bit probe);
    logic [15:0] off_code;
    logic [10:0] len_code;
    logic [10:0] low_part;
    logic [2:0]  high_part;
    logic [7:0]  hdr_bytes [4];
    off_code = 16'(offset - 1);
    case (hdr_len)
      2: begin
        len_code     = 11'(copy_len) - COPY_BIAS_2B;
        hdr_bytes[0] = {1'b0, len_code[2:0], lits, off_code[9:8]};
        hdr_bytes[1] = off_code[7:0];
      end
      3: begin
        len_code     = 11'(copy_len) - COPY_BIAS_3B;
        hdr_bytes[0] = {KIND_FIRST_3B[2:1], len_code[5:0]};
        hdr_bytes[1] = {lits, off_code[13:8]};
        hdr_bytes[2] = off_code[7:0];
      end
      default: begin
        len_code     = 11'(copy_len) - COPY_BIAS_4B;
        high_part    = (len_code[10:7] > 4'd7) ? 3'd7 : len_code[9:7];
        low_part     = len_code - {1'b0, high_part, 7'd0};
        hdr_bytes[0] = {KIND_FIRST_4B, lits, high_part};
        hdr_bytes[1] = off_code[15:8];
        hdr_bytes[2] = off_code[7:0];
        hdr_bytes[3] = low_part[7:0];
      end
    endcase
    for (int i = 0; i < hdr_len; i++) begin
      // drain while the header is still open
      if (probe && i == 1) send_req(OP_DRAIN, 8'($urandom_range(255)));
      send_byte(hdr_bytes[i]);
    end
    send_literals(32'(lits));
    for (int i = 0; i < copy_len; i++) begin
      // byte while the copy is pending
      if (probe && i == 0) send_byte(8'($urandom_range(255)));
      send_req(OP_DRAIN, 8'($urandom_range(255)));
    end
  endtask

  // mostly short and overlapping distances, some far, some the maximum
  function automatic int unsigned pick_offset(input int unsigned max_off);
    case ($urandom_range(9))
      0, 1, 2: return $urandom_range(1, 4);
      3, 4:    return $urandom_range(1, 64);
      9:       return max_off;
      default: return $urandom_range(1, max_off);
    endcase
  endfunction

  // finish whatever random noise left open
  task automatic resync_stream();
    while (decoder_state.header_pending || decoder_state.literals_left != '0 ||
           decoder_state.copies_left != '0) begin
      if (decoder_state.header_pending || decoder_state.literals_left != '0) begin
        send_byte(8'($urandom_range(255)));
      end else begin
        send_req(OP_DRAIN, 8'($urandom_range(255)));
      end
    end
  endtask

  task automatic random_step();
    int unsigned pick;
    int unsigned len_pick;
    int unsigned run_len;
    logic [4:0]  run_code;
    pick = $urandom_range(99);
    if (pick < 28) begin
      copy_cmd(2, 2'($urandom_range(3)), $urandom_range(3, 10), pick_offset(1024),
               $urandom_range(9) == 0);
    end else if (pick < 48) begin
      copy_cmd(3, 2'($urandom_range(3)), $urandom_range(4, 67), pick_offset(16384),
               $urandom_range(9) == 0);
    end else if (pick < 64) begin
      len_pick = $urandom_range(99);
      copy_cmd(4, 2'($urandom_range(3)),
               (len_pick == 0) ? 1156 :
               (len_pick == 1) ? $urandom_range(5, 1156) : $urandom_range(5, 40),
               pick_offset(65536), $urandom_range(9) == 0);
    end else if (pick < 88) begin
      if ($urandom_range(9) == 0) begin
        run_len = $urandom_range(1) ? 32 : $urandom_range(1, 32);
      end else begin
        run_len = $urandom_range(1, 3);
      end
      run_code = 5'(run_len - 1);
      send_byte({KIND_LIT_RUN, run_code});
      send_literals(4 * run_len);
    end else begin
      // noise, then bring the stream back to a command boundary
      repeat ($urandom_range(1, 6)) begin
        send_req(op_e'($urandom_range(1)), 8'($urandom_range(255)));
      end
      resync_stream();
    end
  endtask

  // hold off until every result has come back
  task automatic wait_results();
    req_ch.valid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
  endtask

  // main sequence
  initial begin
    rst_ni         = 1'b0;
    req_ch.valid   = 1'b0;
    req_ch.payload = '{operation: OP_BYTE, in_byte: 8'h00};
    send_idle_pct  = 23;
    recv_idle_pct  = 82;
    accepted_cnt   = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // drain with nothing pending
    send_req(OP_DRAIN, 8'hFF);
    // shortest literal run with extreme bytes
    send_byte({KIND_LIT_RUN, 5'd0});
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA5);
    send_byte(8'h5A);
    // no literals, overlapping copy at distance one, with phase probes
    copy_cmd(2, 2'd0, 3, 1, 1'b1);
    // distance past the written data reads zero
    copy_cmd(3, 2'd1, 4, 16384, 1'b0);
    // largest distance
    copy_cmd(4, 2'd3, 5, 65536, 1'b0);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 23;
          recv_idle_pct = 82;
        end
        1: begin
          send_idle_pct = 82;
          recv_idle_pct = 23;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      while (accepted_cnt < (phase + 1) * ITEM_TARGET / 3) random_step();
      wait_results();
    end

    repeat (8) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #10ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/lzd_pkg.sv
rtl/lzd_stream_if.sv
rtl/lzd_history_ram.sv
rtl/lz_literal_copy_decompressor_unit.sv
sim/lzd_decomp_checker.sv
sim/lz_literal_copy_decompressor_unit_tb.sv
